@@ hw/rtl/kdeb_pkg.sv @@
// Package for the keypad digit entry buffer: widths, operation codes,
// result record and the key/digit helper functions.
// No dependencies.
`timescale 1ns / 1ps

package kdeb_pkg;

  localparam int CMD_W         = 2;
  localparam int KEY_INDEX_W   = 4;
  localparam int KEY_CODE_W    = 5;
  localparam int DIGIT_W       = 4;
  localparam int DIGIT_COUNT_W = 4;
  localparam int VALUE_W       = 27;

  localparam int ROW_SIZE             = 4;
  localparam int DEFAULT_BUFFER_DEPTH = 8;
  localparam int MAX_BUFFER_DEPTH     = 8;

  localparam logic [DIGIT_COUNT_W-1:0] DIGIT_COUNT_RESET = DIGIT_COUNT_W'(8);

  // Command keys (code = key index + 1)
  localparam logic [KEY_CODE_W-1:0] KEY_CMD_A     = KEY_CODE_W'(4);
  localparam logic [KEY_CODE_W-1:0] KEY_CMD_B     = KEY_CODE_W'(8);
  localparam logic [KEY_CODE_W-1:0] KEY_CMD_C     = KEY_CODE_W'(12);
  localparam logic [KEY_CODE_W-1:0] KEY_CMD_STAR  = KEY_CODE_W'(13);
  localparam logic [KEY_CODE_W-1:0] KEY_CMD_HASH  = KEY_CODE_W'(15);
  localparam logic [KEY_CODE_W-1:0] KEY_CMD_D     = KEY_CODE_W'(16);

  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = DIGIT_W'(10);

  typedef enum logic [CMD_W-1:0] {
    OP_SCAN  = 2'd0,
    OP_FETCH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [VALUE_W-1:0]    entry_value;
    logic [KEY_CODE_W-1:0] fetched_command;
    logic                  command_pending;
    logic [KEY_CODE_W-1:0] last_command_code;
    logic [KEY_CODE_W-1:0] newest_entry;
  } result_t;

  function automatic logic is_command_key(input logic [KEY_CODE_W-1:0] code);
    return (code == KEY_CMD_A) || (code == KEY_CMD_B) || (code == KEY_CMD_C) ||
           (code == KEY_CMD_STAR) || (code == KEY_CMD_HASH) || (code == KEY_CMD_D);
  endfunction

  // digit = code - code / ROW_SIZE; ten and above read as zero
  function automatic logic [DIGIT_W-1:0] code_to_digit(input logic [KEY_CODE_W-1:0] code);
    logic [KEY_CODE_W-1:0] d;
    d = code - KEY_CODE_W'(code / ROW_SIZE);
    return (d >= KEY_CODE_W'(DIGIT_LIMIT)) ? '0 : d[DIGIT_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] pow10(input int k);
    logic [VALUE_W-1:0] w;
    case (k)
      0:       w = VALUE_W'(1);
      1:       w = VALUE_W'(10);
      2:       w = VALUE_W'(100);
      3:       w = VALUE_W'(1000);
      4:       w = VALUE_W'(10000);
      5:       w = VALUE_W'(100000);
      6:       w = VALUE_W'(1000000);
      7:       w = VALUE_W'(10000000);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/kdeb_if.sv @@
// Channel interfaces for the keypad digit entry buffer: scan/command input,
// result output and the digit count write channel. Depends on kdeb_pkg.
`timescale 1ns / 1ps

interface kdeb_in_if import kdeb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic                   key_pressed;
  logic [KEY_INDEX_W-1:0] key_index;

  modport source (output valid, cmd, key_pressed, key_index, input ready);
  modport sink   (input valid, cmd, key_pressed, key_index, output ready);
endinterface

interface kdeb_out_if import kdeb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_W-1:0]    entry_value;
  logic [KEY_CODE_W-1:0] fetched_command;
  logic                  command_pending;
  logic [KEY_CODE_W-1:0] last_command_code;
  logic [KEY_CODE_W-1:0] newest_entry;

  modport source (output valid, entry_value, fetched_command, command_pending,
                  last_command_code, newest_entry, input ready);
  modport sink   (input valid, entry_value, fetched_command, command_pending,
                  last_command_code, newest_entry, output ready);
endinterface

interface kdeb_cfg_if import kdeb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DIGIT_COUNT_W-1:0] digit_count;

  modport source (output valid, digit_count, input ready);
  modport sink   (input valid, digit_count, output ready);
endinterface

@@ hw/rtl/keypad_digit_entry_buffer_unit.sv @@
// Keypad digit entry buffer, top level: state update, decimal value and
// a two-entry result buffer. Depends on kdeb_pkg and kdeb_if.
`timescale 1ns / 1ps

// Takes one beat per clock: a scan tick, a command fetch or a buffer clear.
// Each accepted beat updates the key state in the same cycle and produces
// exactly one registered result beat. Throughput is one beat per cycle; the
// output side holds up to two results (output register plus skid), so input
// ready drops only when both are full. digit_count is written through the
// cfg channel, which is always ready; write it only while idle.
module keypad_digit_entry_buffer_unit import kdeb_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  kdeb_in_if.sink    key_in,
  kdeb_cfg_if.sink   cfg,
  kdeb_out_if.source result_out
);

  logic [KEY_CODE_W-1:0]    digit_store [BUFFER_DEPTH];
  logic [KEY_CODE_W-1:0]    digit_store_next [BUFFER_DEPTH];
  logic                     was_pressed, was_pressed_next;
  logic [KEY_CODE_W-1:0]    held_command, held_command_next;
  logic                     pending_flag, pending_flag_next;
  logic [DIGIT_COUNT_W-1:0] digit_count;

  result_t out_reg, skid_reg, result_next;
  logic    out_valid, skid_valid;

  logic                  in_fire, out_fire, take_key;
  logic [KEY_CODE_W-1:0] code;
  logic [VALUE_W-1:0]    value_next;

  assign key_in.ready = !skid_valid;
  assign in_fire      = key_in.valid && key_in.ready;
  assign out_fire     = out_valid && result_out.ready;
  assign cfg.ready    = 1'b1;

  assign code = KEY_CODE_W'(key_in.key_index) + KEY_CODE_W'(1);

  always_comb begin
    digit_store_next  = digit_store;
    was_pressed_next  = was_pressed;
    held_command_next = held_command;
    pending_flag_next = pending_flag;
    result_next       = '0;
    take_key          = 1'b0;

    unique case (op_t'(key_in.cmd))
      OP_SCAN: begin
        // a held key repeats only when it differs from the newest entry
        take_key = key_in.key_pressed &&
                   (!was_pressed || (digit_store[BUFFER_DEPTH-1] != code));
        if (take_key) begin
          if (is_command_key(code)) begin
            held_command_next = code;
            pending_flag_next = 1'b1;
          end else begin
            for (int i = 0; i < BUFFER_DEPTH - 1; i++) begin
              digit_store_next[i] = digit_store[i+1];
            end
            digit_store_next[BUFFER_DEPTH-1] = code;
          end
        end
        was_pressed_next = key_in.key_pressed;
      end
      OP_FETCH: begin
        if (pending_flag) begin
          result_next.fetched_command = held_command;
          pending_flag_next           = 1'b0;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
          digit_store_next[i] = '0;
        end
      end
      default: ;
    endcase

    // newest entry is the units digit; counts past the depth take all entries
    value_next = '0;
    for (int k = 0; k < BUFFER_DEPTH; k++) begin
      if (DIGIT_COUNT_W'(k) < digit_count) begin
        value_next = value_next +
                     VALUE_W'(code_to_digit(digit_store_next[BUFFER_DEPTH-1-k])) * pow10(k);
      end
    end

    result_next.entry_value       = value_next;
    result_next.command_pending   = pending_flag_next;
    result_next.last_command_code = held_command_next;
    result_next.newest_entry      = digit_store_next[BUFFER_DEPTH-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        digit_store[i] <= '0;
      end
      was_pressed  <= 1'b0;
      held_command <= '0;
      pending_flag <= 1'b0;
    end else if (in_fire) begin
      digit_store  <= digit_store_next;
      was_pressed  <= was_pressed_next;
      held_command <= held_command_next;
      pending_flag <= pending_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= DIGIT_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      digit_count <= cfg.digit_count;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_reg   <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign result_out.valid             = out_valid;
  assign result_out.entry_value       = out_reg.entry_value;
  assign result_out.fetched_command   = out_reg.fetched_command;
  assign result_out.command_pending   = out_reg.command_pending;
  assign result_out.last_command_code = out_reg.last_command_code;
  assign result_out.newest_entry      = out_reg.newest_entry;

endmodule
